// ===== hdl/grls_pkg.sv =====
// ----------------------------------------------------------------------------
// grls_pkg: shared types and the solve program
// Widths, operand codes and the step table used by the least squares solver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package grls_pkg;

  localparam int MaxGyros = 16;
  localparam int CntW     = 7;
  localparam int AccW     = 120;       // wide accumulator, holds every exact value
  localparam int YW       = 48;        // serial multiplier operand length
  localparam int DW       = AccW + 34; // divider remainder width
  localparam int PcW      = 5;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ONE,
    MODE_TWO,
    MODE_MANY
  } mode_e;

  typedef enum logic [2:0] {
    OP_MAC,
    OP_DIV,
    OP_CHK,
    OP_SING,
    OP_END
  } op_e;

  typedef enum logic [4:0] {
    SRC_ZERO,
    SRC_G00, SRC_G01, SRC_G02, SRC_G11, SRC_G12, SRC_G22,
    SRC_P0, SRC_P1, SRC_P2,
    SRC_A0, SRC_A1, SRC_A2,
    SRC_B0, SRC_B1, SRC_B2,
    SRC_R0, SRC_R1,
    SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_T4, SRC_T5
  } src_e;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_T0, DST_T1, DST_T2, DST_T3, DST_T4, DST_T5,
    DST_DET,
    DST_OX, DST_OY, DST_OZ
  } dst_e;

  typedef struct packed {
    op_e  op;
    src_e x;
    src_e y;
    logic neg;
    logic clr;
    dst_e dst;
  } step_t;

  typedef struct packed {
    mode_e             mode;
    logic [5:0][35:0]  gram;   // xx xy xz yy yz zz
    logic [2:0][43:0]  proj;
    logic [5:0][15:0]  axes;   // first gyro xyz, second gyro xyz
    logic [1:0][23:0]  rates;
  } solve_in_t;

  function automatic step_t mk(op_e op, src_e x, src_e y, logic neg, logic clr, dst_e dst);
    step_t s;
    s.op  = op;
    s.x   = x;
    s.y   = y;
    s.neg = neg;
    s.clr = clr;
    s.dst = dst;
    return s;
  endfunction

  function automatic step_t mac(src_e x, src_e y, logic neg, logic clr, dst_e dst);
    return mk(OP_MAC, x, y, neg, clr, dst);
  endfunction

  function automatic step_t div(dst_e dst);
    return mk(OP_DIV, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, dst);
  endfunction

  function automatic step_t fin();
    return mk(OP_END, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, DST_NONE);
  endfunction

  // Step table. Each numerator is built in the accumulator and then divided
  // by the determinant register; one gyro divides by 2^28 so that the
  // shared divide stage yields round(rate * axis / 2^14).
  function automatic step_t prog(mode_e m, logic [PcW-1:0] pc);
    step_t s;
    s = fin();
    case (m)
      MODE_ONE: begin
        case (pc)
          5'd0: s = mac(SRC_R0, SRC_A0, 1'b0, 1'b1, DST_NONE);
          5'd1: s = div(DST_OX);
          5'd2: s = mac(SRC_R0, SRC_A1, 1'b0, 1'b1, DST_NONE);
          5'd3: s = div(DST_OY);
          5'd4: s = mac(SRC_R0, SRC_A2, 1'b0, 1'b1, DST_NONE);
          5'd5: s = div(DST_OZ);
          default: s = fin();
        endcase
      end
      MODE_TWO: begin
        case (pc)
          5'd0:  s = mac(SRC_A0, SRC_A0, 1'b0, 1'b1, DST_NONE);
          5'd1:  s = mac(SRC_A1, SRC_A1, 1'b0, 1'b0, DST_NONE);
          5'd2:  s = mac(SRC_A2, SRC_A2, 1'b0, 1'b0, DST_T0);
          5'd3:  s = mac(SRC_B0, SRC_B0, 1'b0, 1'b1, DST_NONE);
          5'd4:  s = mac(SRC_B1, SRC_B1, 1'b0, 1'b0, DST_NONE);
          5'd5:  s = mac(SRC_B2, SRC_B2, 1'b0, 1'b0, DST_T1);
          5'd6:  s = mac(SRC_A0, SRC_B0, 1'b0, 1'b1, DST_NONE);
          5'd7:  s = mac(SRC_A1, SRC_B1, 1'b0, 1'b0, DST_NONE);
          5'd8:  s = mac(SRC_A2, SRC_B2, 1'b0, 1'b0, DST_T2);
          5'd9:  s = mac(SRC_T0, SRC_T1, 1'b0, 1'b1, DST_NONE);
          5'd10: s = mac(SRC_T2, SRC_T2, 1'b1, 1'b0, DST_DET);
          5'd11: s = mac(SRC_T1, SRC_R0, 1'b0, 1'b1, DST_NONE);
          5'd12: s = mac(SRC_T2, SRC_R1, 1'b1, 1'b0, DST_T3);
          5'd13: s = mac(SRC_T0, SRC_R1, 1'b0, 1'b1, DST_NONE);
          5'd14: s = mac(SRC_T2, SRC_R0, 1'b1, 1'b0, DST_T4);
          5'd15: s = mk(OP_CHK, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, DST_NONE);
          5'd16: s = mac(SRC_T3, SRC_A0, 1'b0, 1'b1, DST_NONE);
          5'd17: s = mac(SRC_T4, SRC_B0, 1'b0, 1'b0, DST_NONE);
          5'd18: s = div(DST_OX);
          5'd19: s = mac(SRC_T3, SRC_A1, 1'b0, 1'b1, DST_NONE);
          5'd20: s = mac(SRC_T4, SRC_B1, 1'b0, 1'b0, DST_NONE);
          5'd21: s = div(DST_OY);
          5'd22: s = mac(SRC_T3, SRC_A2, 1'b0, 1'b1, DST_NONE);
          5'd23: s = mac(SRC_T4, SRC_B2, 1'b0, 1'b0, DST_NONE);
          5'd24: s = div(DST_OZ);
          default: s = fin();
        endcase
      end
      MODE_MANY: begin
        case (pc)
          5'd0:  s = mac(SRC_G11, SRC_G22, 1'b0, 1'b1, DST_NONE);
          5'd1:  s = mac(SRC_G12, SRC_G12, 1'b1, 1'b0, DST_T0);
          5'd2:  s = mac(SRC_G12, SRC_G02, 1'b0, 1'b1, DST_NONE);
          5'd3:  s = mac(SRC_G01, SRC_G22, 1'b1, 1'b0, DST_T1);
          5'd4:  s = mac(SRC_G01, SRC_G12, 1'b0, 1'b1, DST_NONE);
          5'd5:  s = mac(SRC_G11, SRC_G02, 1'b1, 1'b0, DST_T2);
          5'd6:  s = mac(SRC_G00, SRC_G22, 1'b0, 1'b1, DST_NONE);
          5'd7:  s = mac(SRC_G02, SRC_G02, 1'b1, 1'b0, DST_T3);
          5'd8:  s = mac(SRC_G02, SRC_G01, 1'b0, 1'b1, DST_NONE);
          5'd9:  s = mac(SRC_G12, SRC_G00, 1'b1, 1'b0, DST_T4);
          5'd10: s = mac(SRC_G00, SRC_G11, 1'b0, 1'b1, DST_NONE);
          5'd11: s = mac(SRC_G01, SRC_G01, 1'b1, 1'b0, DST_T5);
          5'd12: s = mac(SRC_T0, SRC_G00, 1'b0, 1'b1, DST_NONE);
          5'd13: s = mac(SRC_T1, SRC_G01, 1'b0, 1'b0, DST_NONE);
          5'd14: s = mac(SRC_T2, SRC_G02, 1'b0, 1'b0, DST_DET);
          5'd15: s = mk(OP_CHK, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, DST_NONE);
          5'd16: s = mac(SRC_T0, SRC_P0, 1'b0, 1'b1, DST_NONE);
          5'd17: s = mac(SRC_T1, SRC_P1, 1'b0, 1'b0, DST_NONE);
          5'd18: s = mac(SRC_T2, SRC_P2, 1'b0, 1'b0, DST_NONE);
          5'd19: s = div(DST_OX);
          5'd20: s = mac(SRC_T1, SRC_P0, 1'b0, 1'b1, DST_NONE);
          5'd21: s = mac(SRC_T3, SRC_P1, 1'b0, 1'b0, DST_NONE);
          5'd22: s = mac(SRC_T4, SRC_P2, 1'b0, 1'b0, DST_NONE);
          5'd23: s = div(DST_OY);
          5'd24: s = mac(SRC_T2, SRC_P0, 1'b0, 1'b1, DST_NONE);
          5'd25: s = mac(SRC_T4, SRC_P1, 1'b0, 1'b0, DST_NONE);
          5'd26: s = mac(SRC_T5, SRC_P2, 1'b0, 1'b0, DST_NONE);
          5'd27: s = div(DST_OZ);
          default: s = fin();
        endcase
      end
      default: s = mk(OP_SING, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, DST_NONE);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gyro_rate_least_squares.sv =====
// ----------------------------------------------------------------------------
// gyro_rate_least_squares: body rate from single-axis gyros
// Accumulates the normal equations per gyro and solves on the final one.
// ----------------------------------------------------------------------------
//  channel  | signals                                    | direction
//  ---------+--------------------------------------------+----------
//  input    | in_valid_i/in_ready_o, axis_*_i, gyro_rate_i, last_gyro_i | in
//  output   | out_valid_o/out_ready_i, rate_*_o, singular_o             | out
//
// A gyro beat is accepted and then runs nine products through the
// 24x16 accumulate multiplier. The final beat adds the solve, a series of
// multiply-accumulate and divide steps run by the solver, from the start
// of the solve to the result in the output register.
// Reset clears the accumulators and the gyro count. A pending result in the
// output register does not block new beats; only a finished solve waits for it.
`timescale 1ns / 1ps
`default_nettype none

module gyro_rate_least_squares (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  input  logic signed [23:0] gyro_rate_i,
  input  logic               last_gyro_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] rate_x_o,
  output logic signed [31:0] rate_y_o,
  output logic signed [31:0] rate_z_o,
  output logic               singular_o
);
  import grls_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_ACC   = 4'b0010,
    T_SOLVE = 4'b0100,
    T_PUSH  = 4'b1000
  } tstate_e;

  tstate_e              st_q;
  logic [3:0]           k_q;
  logic [CntW-1:0]      cnt_q;
  logic                 last_q;
  logic                 start_q;
  logic signed [15:0]   ax_q, ay_q, az_q;
  logic signed [23:0]   rate_q;
  logic [5:0][35:0]     gram_q;
  logic [2:0][43:0]     proj_q;
  logic [5:0][15:0]     axes_q;
  logic [1:0][23:0]     rates_q;
  logic                 out_valid_q;
  logic signed [31:0]   ox_q, oy_q, oz_q;
  logic                 osing_q;

  logic                 in_acc;
  logic                 counted;
  logic signed [23:0]   ma;
  logic signed [15:0]   mb;
  logic signed [39:0]   prod;
  solve_in_t            si;
  logic                 s_done;
  logic signed [31:0]   s_rx, s_ry, s_rz;
  logic                 s_sing;

  assign in_ready_o = (st_q == T_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign counted    = cnt_q < CntW'(MaxGyros);

  // Product order: xx xy xz yy yz zz, then rate times x, y, z.
  always_comb begin
    case (k_q)
      4'd0:    begin ma = 24'(ax_q); mb = ax_q; end
      4'd1:    begin ma = 24'(ax_q); mb = ay_q; end
      4'd2:    begin ma = 24'(ax_q); mb = az_q; end
      4'd3:    begin ma = 24'(ay_q); mb = ay_q; end
      4'd4:    begin ma = 24'(ay_q); mb = az_q; end
      4'd5:    begin ma = 24'(az_q); mb = az_q; end
      4'd6:    begin ma = rate_q;    mb = ax_q; end
      4'd7:    begin ma = rate_q;    mb = ay_q; end
      default: begin ma = rate_q;    mb = az_q; end
    endcase
    prod = ma * mb;
  end

  always_comb begin
    si.gram  = gram_q;
    si.proj  = proj_q;
    si.axes  = axes_q;
    si.rates = rates_q;
    if (cnt_q == CntW'(0)) begin
      si.mode = MODE_NONE;
    end else if (cnt_q == CntW'(1)) begin
      si.mode = MODE_ONE;
    end else if (cnt_q == CntW'(2)) begin
      si.mode = MODE_TWO;
    end else begin
      si.mode = MODE_MANY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= T_IDLE;
      k_q         <= '0;
      cnt_q       <= '0;
      start_q     <= 1'b0;
      gram_q      <= '0;
      proj_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // In T_PUSH the output register is refilled in the same cycle it drains.
      if (out_valid_q && out_ready_i && st_q != T_PUSH) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        T_IDLE: begin
          if (in_acc) begin
            ax_q   <= axis_x_i;
            ay_q   <= axis_y_i;
            az_q   <= axis_z_i;
            rate_q <= gyro_rate_i;
            last_q <= last_gyro_i;
            k_q    <= '0;
            if (counted) begin
              cnt_q <= cnt_q + 1'b1;
              if (cnt_q == CntW'(0)) begin
                axes_q[0]  <= axis_x_i;
                axes_q[1]  <= axis_y_i;
                axes_q[2]  <= axis_z_i;
                rates_q[0] <= gyro_rate_i;
              end else if (cnt_q == CntW'(1)) begin
                axes_q[3]  <= axis_x_i;
                axes_q[4]  <= axis_y_i;
                axes_q[5]  <= axis_z_i;
                rates_q[1] <= gyro_rate_i;
              end
              st_q <= T_ACC;
            end else if (last_gyro_i) begin
              start_q <= 1'b1;
              st_q    <= T_SOLVE;
            end
          end
        end
        T_ACC: begin
          case (k_q)
            4'd0:    gram_q[0] <= gram_q[0] + prod[35:0];
            4'd1:    gram_q[1] <= gram_q[1] + prod[35:0];
            4'd2:    gram_q[2] <= gram_q[2] + prod[35:0];
            4'd3:    gram_q[3] <= gram_q[3] + prod[35:0];
            4'd4:    gram_q[4] <= gram_q[4] + prod[35:0];
            4'd5:    gram_q[5] <= gram_q[5] + prod[35:0];
            4'd6:    proj_q[0] <= proj_q[0] + 44'(prod);
            4'd7:    proj_q[1] <= proj_q[1] + 44'(prod);
            default: proj_q[2] <= proj_q[2] + 44'(prod);
          endcase
          k_q <= k_q + 1'b1;
          if (k_q == 4'd8) begin
            if (last_q) begin
              start_q <= 1'b1;
              st_q    <= T_SOLVE;
            end else begin
              st_q <= T_IDLE;
            end
          end
        end
        T_SOLVE: begin
          start_q <= 1'b0;
          if (s_done) begin
            st_q <= T_PUSH;
          end
        end
        T_PUSH: begin
          if (!out_valid_q || out_ready_i) begin
            ox_q        <= s_rx;
            oy_q        <= s_ry;
            oz_q        <= s_rz;
            osing_q     <= s_sing;
            out_valid_q <= 1'b1;
            gram_q      <= '0;
            proj_q      <= '0;
            cnt_q       <= '0;
            st_q        <= T_IDLE;
          end
        end
        default: st_q <= T_IDLE;
      endcase
    end
  end

  grls_solver u_solver (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .solve_i    (si),
    .done_o     (s_done),
    .rate_x_o   (s_rx),
    .rate_y_o   (s_ry),
    .rate_z_o   (s_rz),
    .singular_o (s_sing)
  );

  assign out_valid_o = out_valid_q;
  assign rate_x_o    = ox_q;
  assign rate_y_o    = oy_q;
  assign rate_z_o    = oz_q;
  assign singular_o  = osing_q;

endmodule

`default_nettype wire

// ===== hdl/grls_solver.sv =====
// ----------------------------------------------------------------------------
// grls_solver: sequenced wide solve
// A shift-add multiply-accumulate and a restoring divide with rounding
// and saturation, stepped through the package program.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grls_solver (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  grls_pkg::solve_in_t solve_i,
  output logic                done_o,
  output logic signed [31:0]  rate_x_o,
  output logic signed [31:0]  rate_y_o,
  output logic signed [31:0]  rate_z_o,
  output logic                singular_o
);
  import grls_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FETCH  = 6'b000010,
    S_MUL    = 6'b000100,
    S_DIVPRE = 6'b001000,
    S_DIV    = 6'b010000,
    S_DONE   = 6'b100000
  } sstate_e;

  localparam logic [5:0] MulLast = 6'(YW - 1);
  localparam logic [5:0] DivLast = 6'd32;

  sstate_e                 st_q;
  logic [PcW-1:0]          pc_q;
  logic signed [AccW-1:0]  acc_q;
  logic [AccW-1:0]         xr_q;
  logic [YW-1:0]           yr_q;
  logic [5:0]              cnt_q;
  logic                    qneg_q;
  logic [DW-1:0]           rem_q;
  logic [DW-1:0]           dv_q;
  logic [32:0]             quo_q;
  logic signed [AccW-1:0]  det_q;
  logic [5:0][AccW-1:0]    t_q;
  logic signed [31:0]      rx_q, ry_q, rz_q;
  logic                    sing_q;
  dst_e                    dst_q;

  step_t                   step;
  logic signed [AccW-1:0]  xv, yv, ymag_full, nm, dm;
  logic [AccW-1:0]         msum;
  logic                    ge;
  logic [32:0]             qfin;
  logic signed [31:0]      qsat;

  function automatic logic signed [AccW-1:0] pick(src_e s, solve_in_t si,
                                                  logic [5:0][AccW-1:0] t);
    logic signed [AccW-1:0] v;
    case (s)
      SRC_G00: v = AccW'($signed(si.gram[0]));
      SRC_G01: v = AccW'($signed(si.gram[1]));
      SRC_G02: v = AccW'($signed(si.gram[2]));
      SRC_G11: v = AccW'($signed(si.gram[3]));
      SRC_G12: v = AccW'($signed(si.gram[4]));
      SRC_G22: v = AccW'($signed(si.gram[5]));
      SRC_P0:  v = AccW'($signed(si.proj[0]));
      SRC_P1:  v = AccW'($signed(si.proj[1]));
      SRC_P2:  v = AccW'($signed(si.proj[2]));
      SRC_A0:  v = AccW'($signed(si.axes[0]));
      SRC_A1:  v = AccW'($signed(si.axes[1]));
      SRC_A2:  v = AccW'($signed(si.axes[2]));
      SRC_B0:  v = AccW'($signed(si.axes[3]));
      SRC_B1:  v = AccW'($signed(si.axes[4]));
      SRC_B2:  v = AccW'($signed(si.axes[5]));
      SRC_R0:  v = AccW'($signed(si.rates[0]));
      SRC_R1:  v = AccW'($signed(si.rates[1]));
      SRC_T0:  v = $signed(t[0]);
      SRC_T1:  v = $signed(t[1]);
      SRC_T2:  v = $signed(t[2]);
      SRC_T3:  v = $signed(t[3]);
      SRC_T4:  v = $signed(t[4]);
      SRC_T5:  v = $signed(t[5]);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(logic [32:0] q, logic neg);
    logic signed [31:0] r;
    if (!neg) begin
      r = (q > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(q[31:0]);
    end else begin
      r = (q > 33'h080000000) ? 32'sh80000000 : $signed(-q[31:0]);
    end
    return r;
  endfunction

  always_comb begin
    step      = prog(solve_i.mode, pc_q);
    xv        = pick(step.x, solve_i, t_q);
    yv        = pick(step.y, solve_i, t_q);
    ymag_full = yv[AccW-1] ? -yv : yv;
    nm        = acc_q[AccW-1] ? -acc_q : acc_q;
    dm        = det_q[AccW-1] ? -det_q : det_q;
    msum      = acc_q + (yr_q[0] ? xr_q : '0);
    ge        = rem_q >= dv_q;
    qfin      = {quo_q[31:0], ge};
    qsat      = sat32(qfin, qneg_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      pc_q   <= '0;
      cnt_q  <= '0;
      sing_q <= 1'b0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (start_i) begin
            pc_q   <= '0;
            det_q  <= AccW'(1) <<< 28;
            rx_q   <= '0;
            ry_q   <= '0;
            rz_q   <= '0;
            sing_q <= 1'b0;
            st_q   <= S_FETCH;
          end
        end
        S_FETCH: begin
          case (step.op)
            OP_MAC: begin
              xr_q  <= (yv[AccW-1] ^ step.neg) ? -xv : xv;
              yr_q  <= ymag_full[YW-1:0];
              dst_q <= step.dst;
              cnt_q <= '0;
              if (step.clr) begin
                acc_q <= '0;
              end
              st_q <= S_MUL;
            end
            OP_DIV: begin
              // Rounded quotient is floor((2|n| + |d|) / (2|d|)) with n scaled by 2^14.
              rem_q  <= (DW'(nm) << 15) + DW'(dm);
              dv_q   <= DW'(dm) << 33;
              qneg_q <= acc_q[AccW-1] ^ det_q[AccW-1];
              dst_q  <= step.dst;
              st_q   <= S_DIVPRE;
            end
            OP_CHK: begin
              if (det_q == '0) begin
                sing_q <= 1'b1;
                st_q   <= S_DONE;
              end else begin
                pc_q <= pc_q + 1'b1;
              end
            end
            OP_SING: begin
              sing_q <= 1'b1;
              st_q   <= S_DONE;
            end
            default: st_q <= S_DONE;
          endcase
        end
        S_MUL: begin
          acc_q <= msum;
          xr_q  <= xr_q << 1;
          yr_q  <= yr_q >> 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == MulLast) begin
            case (dst_q)
              DST_T0:  t_q[0] <= msum;
              DST_T1:  t_q[1] <= msum;
              DST_T2:  t_q[2] <= msum;
              DST_T3:  t_q[3] <= msum;
              DST_T4:  t_q[4] <= msum;
              DST_T5:  t_q[5] <= msum;
              DST_DET: det_q  <= msum;
              default: ;
            endcase
            pc_q <= pc_q + 1'b1;
            st_q <= S_FETCH;
          end
        end
        S_DIVPRE: begin
          // A quotient of 2^33 or more saturates without running the divide.
          if (rem_q >= (dv_q << 1)) begin
            case (dst_q)
              DST_OX:  rx_q <= qneg_q ? 32'sh80000000 : 32'sh7FFFFFFF;
              DST_OY:  ry_q <= qneg_q ? 32'sh80000000 : 32'sh7FFFFFFF;
              DST_OZ:  rz_q <= qneg_q ? 32'sh80000000 : 32'sh7FFFFFFF;
              default: ;
            endcase
            pc_q <= pc_q + 1'b1;
            st_q <= S_FETCH;
          end else begin
            quo_q <= '0;
            cnt_q <= '0;
            st_q  <= S_DIV;
          end
        end
        S_DIV: begin
          if (ge) begin
            rem_q <= rem_q - dv_q;
          end
          dv_q  <= dv_q >> 1;
          quo_q <= qfin;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivLast) begin
            case (dst_q)
              DST_OX:  rx_q <= qsat;
              DST_OY:  ry_q <= qsat;
              DST_OZ:  rz_q <= qsat;
              default: ;
            endcase
            pc_q <= pc_q + 1'b1;
            st_q <= S_FETCH;
          end
        end
        S_DONE: st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign done_o     = (st_q == S_DONE);
  assign rate_x_o   = rx_q;
  assign rate_y_o   = ry_q;
  assign rate_z_o   = rz_q;
  assign singular_o = sing_q;

endmodule

`default_nettype wire
